>>> design/tccp_pkg.sv
`default_nettype none

package tccp_pkg;

    // file header: identifier bytes, then minor and major version
    localparam logic [3:0] IDENT_BYTES    = 4'd10;
    // byte index of the sixth (last) chunk header byte
    localparam logic [2:0] CHUNK_LAST_IDX = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DATA_W  = 104;

    typedef enum logic [2:0] {
        PH_FILE_HDR  = 3'b001,
        PH_CHUNK_HDR = 3'b010,
        PH_PAYLOAD   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_BAD_IDENT = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef enum logic {
        KIND_CHUNK = 1'b0,
        KIND_DONE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] chunk_id;
        logic [31:0] chunk_length;
        logic [31:0] payload_offset;
        logic [7:0]  version_minor;
        logic [7:0]  version_major;
        status_t     status;
    } record_t;

    function automatic logic [7:0] ident_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h55;
            4'd1:    b = 8'h45;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h46;
            4'd5:    b = 8'h69;
            4'd6:    b = 8'h6C;
            4'd7:    b = 8'h65;
            4'd8:    b = 8'h21;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/tape_container_chunk_parser.sv
// chunk container parser
// s_* channel: one file byte per beat, s_tlast on the final byte of a file.
// m_* channel: one record per beat; m_tuser 0 is a chunk record, 1 a done record.
// a chunk record comes out for every 6-byte chunk header that is not the final
// byte; a done record with the parse status comes out on the final byte.
// chunk records always carry status ok, so drop them unless the done record says ok.
// throughput: one byte per cycle while the record queue is not full; the front
// parser updates its counters and assembly registers as each byte is accepted.
// path: a record passes through the record queue and then the output register
// before it is on m_tdata; a stalled receiver can hold it in the queue.
// stall: a two-entry record queue plus the output register absorb a stalled
// receiver; s_tready drops only when the queue is full.
// reset: parser returns to the file header, queue and output are emptied.
// after each done record the parser is back in that state for the next file.
`default_nettype none

module tape_container_chunk_parser
    import tccp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // file_byte
    input  logic                  s_tlast,   // end_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // chunk_id, chunk_length, payload_offset,
                                             // version_minor, version_major, parse_status
    output logic                  m_tuser    // record_kind
);

    logic    in_accept;
    logic    rec_push;
    record_t push_rec;
    record_t pop_rec;
    logic    q_pop;
    logic    q_empty;
    logic    q_full;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    tccp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .rec_push  (rec_push),
        .rec       (push_rec)
    );

    tccp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    tccp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> design/tccp_front.sv
`default_nettype none

module tccp_front
    import tccp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       rec_push,
    output record_t    rec
);

    localparam int POS_W = OFFSET_BITS + 1;
    localparam int EXT_W = (POS_W > 32) ? POS_W : 32;
    localparam logic [POS_W-1:0] POS_STUCK = {1'b1, {(OFFSET_BITS-1){1'b0}}, 1'b1};

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       k_reg, k_next;
    logic [15:0]      id_reg, id_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      rem_reg, rem_next;
    logic             mismatch_reg, mismatch_next;
    logic [7:0]       vmin_reg, vmin_next;
    logic [7:0]       vmaj_reg, vmaj_next;

    logic [POS_W-1:0] pos_inc;
    logic [EXT_W-1:0] inc_ext;
    logic [3:0]       pos_lo;
    logic [15:0]      id_cur;
    logic [31:0]      len_cur;
    logic [31:0]      rem_dec;
    logic             emit_chunk;
    status_t          status;

    assign pos_inc = pos_reg + POS_W'(1);
    assign inc_ext = EXT_W'(pos_inc);
    assign pos_lo  = pos_reg[3:0];
    assign rem_dec = rem_reg - 32'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        mismatch_next = mismatch_reg;
        vmin_next     = vmin_reg;
        vmaj_next     = vmaj_reg;
        id_cur        = id_reg;
        len_cur       = len_reg;
        emit_chunk    = 1'b0;
        status        = ST_OK;
        rec           = '0;
        rec_push      = 1'b0;

        if (in_accept)
        begin
            pos_next = pos_reg[OFFSET_BITS] ? POS_STUCK : pos_inc;

            unique case (phase_reg)
                PH_FILE_HDR:
                begin
                    // position never passes 11 in this phase
                    if (pos_lo < IDENT_BYTES)
                    begin
                        if (in_byte != ident_byte(pos_lo))
                            mismatch_next = 1'b1;
                    end
                    else if (pos_lo == IDENT_BYTES)
                        vmin_next = in_byte;
                    else
                    begin
                        vmaj_next  = in_byte;
                        phase_next = PH_CHUNK_HDR;
                        k_next     = '0;
                    end
                end
                PH_CHUNK_HDR:
                begin
                    case (k_reg)
                        3'd0:    id_cur[7:0]    = in_byte;
                        3'd1:    id_cur[15:8]   = in_byte;
                        3'd2:    len_cur[7:0]   = in_byte;
                        3'd3:    len_cur[15:8]  = in_byte;
                        3'd4:    len_cur[23:16] = in_byte;
                        default: len_cur[31:24] = in_byte;
                    endcase
                    if (k_reg == CHUNK_LAST_IDX)
                    begin
                        // a header ending on the last byte gives no chunk record
                        if (!in_last)
                        begin
                            emit_chunk = 1'b1;
                            if (len_cur != '0)
                            begin
                                rem_next   = len_cur;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        k_next   = '0;
                        id_next  = '0;
                        len_next = '0;
                    end
                    else
                    begin
                        k_next   = k_reg + 3'd1;
                        id_next  = id_cur;
                        len_next = len_cur;
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                        phase_next = PH_CHUNK_HDR;
                end
                default:
                begin
                    phase_next = PH_FILE_HDR;
                end
            endcase

            if (in_last)
            begin
                if (phase_next == PH_FILE_HDR)
                    status = ST_TOO_SMALL;
                else if (mismatch_next)
                    status = ST_BAD_IDENT;
                else if (pos_reg[OFFSET_BITS])
                    status = ST_TOO_LONG;
                else if (phase_next == PH_PAYLOAD)
                    status = ST_OVERRUN;

                rec.kind   = KIND_DONE;
                rec.status = status;
                if (status == ST_OK)
                begin
                    rec.version_minor = vmin_next;
                    rec.version_major = vmaj_next;
                end
                rec_push = 1'b1;

                // next beat starts a new file
                phase_next    = PH_FILE_HDR;
                pos_next      = '0;
                k_next        = '0;
                id_next       = '0;
                len_next      = '0;
                rem_next      = '0;
                mismatch_next = 1'b0;
                vmin_next     = '0;
                vmaj_next     = '0;
            end
            else if (emit_chunk)
            begin
                rec.kind           = KIND_CHUNK;
                rec.chunk_id       = id_cur;
                rec.chunk_length   = len_cur;
                rec.payload_offset = inc_ext[31:0];
                rec.version_minor  = vmin_reg;
                rec.version_major  = vmaj_reg;
                rec.status         = ST_OK;
                rec_push           = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FILE_HDR;
            pos_reg      <= '0;
            k_reg        <= '0;
            id_reg       <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            mismatch_reg <= 1'b0;
            vmin_reg     <= '0;
            vmaj_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            mismatch_reg <= mismatch_next;
            vmin_reg     <= vmin_next;
            vmaj_reg     <= vmaj_next;
        end
    end

endmodule

`default_nettype wire

>>> design/tccp_queue.sv
`default_nettype none

module tccp_queue
    import tccp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    input  logic    pop,
    output record_t pop_rec,
    output logic    empty,
    output logic    full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    record_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_FULL);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> design/tccp_back.sv
`default_nettype none

module tccp_back
    import tccp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  record_t               q_rec,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic    valid_reg, valid_next;
    record_t rec_reg;

    // refill the output beat when it is empty or being taken
    assign q_pop      = !q_empty && (!valid_reg || m_tready);
    assign valid_next = q_pop ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge clk)
    begin
        if (q_pop)
            rec_reg <= q_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = rec_reg.kind;
    assign m_tdata  = {5'b0, rec_reg.status, rec_reg.version_major, rec_reg.version_minor,
                       rec_reg.payload_offset, rec_reg.chunk_length, rec_reg.chunk_id};

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    import tccp_pkg::*;

    // offset width of the default build, too long is out of reach of a short run
    localparam int OFFSET_BITS = 32;
    localparam longint FILE_LIMIT = 64'd1 << OFFSET_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam logic [79:0] FILE_MAGIC = 80'h00_21_65_6C_69_46_20_46_45_55;
    localparam int NO_CORRUPTION = -1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;   // file_byte
    logic                  s_tlast = 1'b0;    // end_of_file
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // chunk_id, chunk_length, payload_offset,
                                              // version_minor, version_major, parse_status
    logic                  m_tuser;           // record_kind

    tape_container_chunk_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // parser state mirrored by the predictor
    phase_t      rx_phase;
    logic [63:0] rx_pos;
    logic [2:0]  hdr_count;
    logic [15:0] id_acc;
    logic [31:0] len_acc;
    logic [31:0] bytes_left;
    logic        magic_bad;
    logic [7:0]  minor_seen;
    logic [7:0]  major_seen;

    record_t     expected_records[$];
    logic [7:0]  file_bytes[$];

    int errors = 0;
    int cycle_count = 0;
    int files_sent = 0;
    int bytes_sent = 0;
    int records_checked = 0;
    int chunk_records = 0;
    int done_by_status[5] = '{default: 0};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    task automatic clear_parser_state();
        rx_phase   = PH_FILE_HDR;
        rx_pos     = '0;
        hdr_count  = '0;
        id_acc     = '0;
        len_acc    = '0;
        bytes_left = '0;
        magic_bad  = 1'b0;
        minor_seen = '0;
        major_seen = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [63:0] cur;
        logic        over;
        record_t     rec;
        status_t     st;
        cur  = rx_pos;
        over = 1'b0;
        if (cur >= FILE_LIMIT)
        begin
            over   = 1'b1;
            rx_pos = FILE_LIMIT + 1;
        end
        else
        begin
            rx_pos = cur + 1;
        end
        case (rx_phase)
            PH_FILE_HDR:
            begin
                if (cur < IDENT_BYTES)
                begin
                    if (b != FILE_MAGIC[8*cur[3:0] +: 8])
                        magic_bad = 1'b1;
                end
                else if (cur == IDENT_BYTES)
                begin
                    minor_seen = b;
                end
                else
                begin
                    major_seen = b;
                    rx_phase   = PH_CHUNK_HDR;
                    hdr_count  = '0;
                end
            end
            PH_CHUNK_HDR:
            begin
                if (hdr_count < 2)
                    id_acc[8*hdr_count[0] +: 8] = b;
                else
                    len_acc[8*(hdr_count-2) +: 8] = b;
                if (hdr_count == CHUNK_LAST_IDX)
                begin
                    if (!last)
                    begin
                        rec                = '0;
                        rec.kind           = KIND_CHUNK;
                        rec.chunk_id       = id_acc;
                        rec.chunk_length   = len_acc;
                        rec.payload_offset = cur[31:0] + 32'd1;
                        rec.version_minor  = minor_seen;
                        rec.version_major  = major_seen;
                        rec.status         = ST_OK;
                        expected_records.insert(expected_records.size(), rec);
                        chunk_records++;
                        if (len_acc != 0)
                        begin
                            bytes_left = len_acc;
                            rx_phase   = PH_PAYLOAD;
                        end
                    end
                    hdr_count = '0;
                    id_acc    = '0;
                    len_acc   = '0;
                end
                else
                begin
                    hdr_count = hdr_count + 3'd1;
                end
            end
            default:
            begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0)
                    rx_phase = PH_CHUNK_HDR;
            end
        endcase
        if (last)
        begin
            st = ST_OK;
            if (rx_phase == PH_FILE_HDR)
                st = ST_TOO_SMALL;
            else if (magic_bad)
                st = ST_BAD_IDENT;
            else if (over || rx_pos > FILE_LIMIT)
                st = ST_TOO_LONG;
            else if (rx_phase == PH_PAYLOAD && bytes_left != 0)
                st = ST_OVERRUN;
            rec        = '0;
            rec.kind   = KIND_DONE;
            rec.status = st;
            if (st == ST_OK)
            begin
                rec.version_minor = minor_seen;
                rec.version_major = major_seen;
            end
            expected_records.insert(expected_records.size(), rec);
            done_by_status[int'(st)]++;
            clear_parser_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
        file_bytes.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_records.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_file_header(input logic [7:0] minor, input logic [7:0] major,
                                   input int bad_idx);
        for (int i = 0; i < IDENT_BYTES; i++)
            file_bytes.insert(file_bytes.size(), FILE_MAGIC[8*i +: 8] ^
                              ((i == bad_idx) ? 8'($urandom_range(255, 1)) : 8'h00));
        file_bytes.insert(file_bytes.size(), minor);
        file_bytes.insert(file_bytes.size(), major);
    endtask

    task automatic add_chunk_header(input logic [15:0] id, input logic [31:0] len);
        file_bytes.insert(file_bytes.size(), id[7:0]);
        file_bytes.insert(file_bytes.size(), id[15:8]);
        for (int i = 0; i < 4; i++)
            file_bytes.insert(file_bytes.size(), len[8*i +: 8]);
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n)
            file_bytes.insert(file_bytes.size(), 8'($urandom));
    endtask

    task automatic trim_file(input int keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_records.size() == 0)
            begin
                errors++;
                $display("%0t: record beat with nothing expected, kind %0b data %0h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("record_kind", 32'(want.kind), 32'(m_tuser));
                check_field("chunk_id", 32'(want.chunk_id), 32'(m_tdata[15:0]));
                check_field("chunk_length", want.chunk_length, m_tdata[47:16]);
                check_field("payload_offset", want.payload_offset, m_tdata[79:48]);
                check_field("version_minor", 32'(want.version_minor), 32'(m_tdata[87:80]));
                check_field("version_major", 32'(want.version_major), 32'(m_tdata[95:88]));
                check_field("parse_status", 32'(want.status), 32'(m_tdata[98:96]));
                records_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d records still expected", $time,
                     expected_records.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_header_checks();
        // lone byte, short header, header only, corrupted identifier
        file_bytes.insert(file_bytes.size(), 8'hFF);
        send_file();
        add_file_header(8'h00, 8'hFF, NO_CORRUPTION);
        trim_file(11);
        send_file();
        add_file_header(8'h00, 8'hFF, NO_CORRUPTION);
        send_file();
        add_file_header(8'h05, 8'h01, 0);
        add_chunk_header(16'h0009, 32'd100);
        add_random_bytes(1);
        send_file();
        // too small wins over bad identifier
        add_file_header(8'h05, 8'h01, 3);
        trim_file(5);
        send_file();
        add_file_header(8'hFF, 8'h00, 9);
        send_file();
    endtask

    task automatic test_chunk_layouts();
        // a zero-length chunk followed directly by the next header
        add_file_header(8'h01, 8'h02, NO_CORRUPTION);
        add_chunk_header(16'hFFFF, 32'd0);
        add_chunk_header(16'h0000, 32'd3);
        add_random_bytes(3);
        add_chunk_header(16'h5AA5, 32'd1);
        add_random_bytes(1);
        send_file();
        // header whose sixth byte closes the file
        add_file_header(8'h03, 8'h04, NO_CORRUPTION);
        add_chunk_header(16'h0102, 32'h0000_0304);
        send_file();
        // trailing partial header
        add_file_header(8'h10, 8'h20, NO_CORRUPTION);
        add_chunk_header(16'h0007, 32'd2);
        add_random_bytes(5);
        send_file();
        // payload cut short
        add_file_header(8'h7F, 8'h80, NO_CORRUPTION);
        add_chunk_header(16'h8000, 32'hFFFF_FFFF);
        add_random_bytes(2);
        send_file();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        add_file_header(8'h22, 8'h33, NO_CORRUPTION);
        repeat (12)
            add_chunk_header(16'($urandom), 32'd0);
        add_random_bytes(1);
        send_file();
        wait_drained();
        add_file_header(8'h44, 8'h55, NO_CORRUPTION);
        add_chunk_header(16'h00AA, 32'd4);
        add_random_bytes(4);
        send_file();
    endtask

    task automatic send_random_file();
        int pick;
        int n_chunks;
        logic [31:0] len;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            add_random_bytes($urandom_range(30, 1));
        end
        else
        begin
            add_file_header(8'($urandom), 8'($urandom),
                            (pick < 14) ? int'($urandom_range(9)) : NO_CORRUPTION);
            n_chunks = $urandom_range(5);
            for (int c = 0; c < n_chunks; c++)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    add_chunk_header(16'($urandom), 32'd0);
                end
                else if (pick < 85)
                begin
                    len = $urandom_range(12, 1);
                    add_chunk_header(16'($urandom), len);
                    add_random_bytes(int'(len));
                end
                else
                begin
                    // huge length: the file runs out inside the payload
                    len = $urandom | 32'h0001_0000;
                    add_chunk_header(16'($urandom), len);
                    add_random_bytes($urandom_range(3));
                    break;
                end
            end
            pick = $urandom_range(99);
            if (pick < 20)
                add_random_bytes($urandom_range(5, 1));
            else if (pick < 35)
                add_chunk_header(16'($urandom), $urandom);
            else if (pick < 50)
                trim_file(file_bytes.size() - $urandom_range(8, 1));
        end
        send_file();
    endtask

    task automatic test_random_files();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if (bytes_sent - start_bytes < RANDOM_BYTES / 3)
            begin
                send_idle_pct  = 11;
                recv_stall_pct = 57;
            end
            else if (bytes_sent - start_bytes < 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 11;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_random_file();
        end
    endtask

    initial
    begin
        clear_parser_state();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct  = 11;
        recv_stall_pct = 57;
        test_header_checks();
        test_chunk_layouts();
        test_backpressure();
        test_random_files();
        wait_drained();
        repeat (10)
            @(posedge clk);
        $display("files %0d, bytes %0d, records checked %0d (%0d chunk records)",
                 files_sent, bytes_sent, records_checked, chunk_records);
        $display("done status ok %0d, too small %0d, bad ident %0d, overrun %0d, too long %0d",
                 done_by_status[0], done_by_status[1], done_by_status[2],
                 done_by_status[3], done_by_status[4]);
        if (errors == 0 && expected_records.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/tccp_pkg.sv
design/tccp_front.sv
design/tccp_queue.sv
design/tccp_back.sv
design/tape_container_chunk_parser.sv
tb/tb.sv
